>>> hdl/cpat_pkg.sv
// Shared definitions for the contiguous page allocator table.
// Holds function codes, status codes and the storage write-control struct.
// No dependencies.
`timescale 1ns / 1ps

package cpat_pkg;

    // Function codes carried by an input word
    localparam logic [2:0] FUNC_ALLOC = 3'd0;
    localparam logic [2:0] FUNC_MAP   = 3'd1;
    localparam logic [2:0] FUNC_FIND  = 3'd2;
    localparam logic [2:0] FUNC_INVAL = 3'd3;
    localparam logic [2:0] FUNC_READ  = 3'd4;

    // Status codes carried by a result word
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_RUN   = 2'd1;
    localparam logic [1:0] ST_NO_ENTRY = 2'd2;

    // Contents of an entry that was never written
    localparam logic [15:0] ID_EMPTY   = 16'hFFFF;
    localparam logic [31:0] ADDR_EMPTY = 32'hFFFF_FFFF;

    // Write strobes into the entry storage
    typedef struct packed {
        logic page_we;
        logic addr_we;
    } store_wr_t;

endpackage

>>> hdl/cpat_store.sv
// Entry storage of the page allocator table: page ids, owner ids and bound addresses.
// One write port and one registered read port shared by all three arrays.
// Depends on cpat_pkg.
`timescale 1ns / 1ps

module cpat_store #(
    parameter int ENTRIES = 32
) (
    input  logic                      clk,
    input  cpat_pkg::store_wr_t       wr,
    input  logic [$clog2(ENTRIES)-1:0] wr_index,
    input  logic [15:0]               wr_page,
    input  logic [15:0]               wr_owner,
    input  logic [31:0]               wr_address,
    input  logic [$clog2(ENTRIES)-1:0] rd_index,
    output logic [15:0]               rd_page,
    output logic [15:0]               rd_owner,
    output logic [31:0]               rd_address
);
    import cpat_pkg::*;

    logic [15:0] page_mem  [ENTRIES];
    logic [15:0] owner_mem [ENTRIES];
    logic [31:0] addr_mem  [ENTRIES];

    logic [15:0] rd_page_reg;
    logic [15:0] rd_owner_reg;
    logic [31:0] rd_address_reg;

    // Write page and owner together on allocation, address on mapping
    always_ff @(posedge clk)
    begin
        if (wr.page_we)
        begin
            page_mem[wr_index]  <= wr_page;
            owner_mem[wr_index] <= wr_owner;
        end
        if (wr.addr_we)
        begin
            addr_mem[wr_index] <= wr_address;
        end
    end

    // Register the read word
    always_ff @(posedge clk)
    begin
        rd_page_reg    <= page_mem[rd_index];
        rd_owner_reg   <= owner_mem[rd_index];
        rd_address_reg <= addr_mem[rd_index];
    end

    assign rd_page    = rd_page_reg;
    assign rd_owner   = rd_owner_reg;
    assign rd_address = rd_address_reg;

endmodule

>>> hdl/contiguous_page_allocator_table.sv
// Page table of ENTRIES entries with a first-fit contiguous allocator. A small
// sequencer walks the entries one per cycle and handles one word at a time;
// in_ready is high only while it is idle. An allocate word scans entries until
// the first free run of page_count entries ends (at most ENTRIES entries), then
// writes the run and posts the result. A map word scans up to ENTRIES entries
// and a find word up to min(LOOKUP_ENTRIES, ENTRIES), both through the single
// storage read port that the scan walks. Invalidate and unknown words post their
// result directly; a read first waits for the registered storage word. A
// finished result waits in the output register while the next word is accepted;
// the sequencer stalls only if a second result is ready before the first is
// taken. Entry flags live in flip-flops cleared by reset, so no clearing pass is
// needed after reset.
`timescale 1ns / 1ps

module contiguous_page_allocator_table #(
    parameter int ENTRIES        = 32,
    parameter int LOOKUP_ENTRIES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  func,
    input  logic [5:0]  page_count,
    input  logic [15:0] alloc_tag,
    input  logic [31:0] target_address,
    input  logic [4:0]  entry_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [15:0] new_alloc_id,
    output logic [15:0] page_number,
    output logic [4:0]  hit_index,
    output logic        entry_allocated,
    output logic        entry_valid,
    output logic        entry_writable,
    output logic [31:0] entry_address
);
    import cpat_pkg::*;

    localparam int IW     = $clog2(ENTRIES);
    localparam int CW     = $clog2(ENTRIES + 1);
    localparam int CMPW   = (CW > 6) ? CW : 6;
    localparam int LOOK_N = (LOOKUP_ENTRIES < ENTRIES) ? LOOKUP_ENTRIES : ENTRIES;
    localparam logic [CW-1:0] MAP_LIM  = CW'(ENTRIES);
    localparam logic [CW-1:0] FIND_LIM = CW'(LOOK_N);

    typedef enum logic [2:0] {
        IDLE,
        ALLOC_SCAN,
        ALLOC_WRITE,
        MAP_SCAN,
        FIND_SCAN,
        READ_WAIT,
        RESP
    } state_t;

    state_t state_reg;

    // Entry flags
    logic [ENTRIES-1:0] alloc_flags_reg;
    logic [ENTRIES-1:0] valid_flags_reg;
    logic [ENTRIES-1:0] bound_flags_reg;
    logic [ENTRIES-1:0] write_flags_reg;
    logic [15:0]        last_alloc_reg;
    logic [15:0]        last_page_reg;

    // Captured input word
    logic [5:0]  count_reg;
    logic [15:0] tag_reg;
    logic [31:0] addr_reg;
    logic [IW-1:0] idx_reg;
    logic        idx_ok_reg;

    // Scan state
    logic [CW-1:0] ptr_reg;
    logic [CW-1:0] run_reg;
    logic [IW-1:0] start_reg;
    logic [IW-1:0] wptr_reg;
    logic [5:0]    remain_reg;
    logic [IW-1:0] cmp_idx_reg;
    logic          cmp_ok_reg;

    // Pending result
    logic [1:0]  res_status_reg;
    logic [15:0] res_id_reg;
    logic [15:0] res_page_reg;
    logic [4:0]  res_hit_reg;
    logic        res_alloc_reg;
    logic        res_valid_reg;
    logic        res_write_reg;
    logic [31:0] res_addr_reg;

    // Output register
    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic [15:0] new_alloc_id_reg;
    logic [15:0] page_number_reg;
    logic [4:0]  hit_index_reg;
    logic        entry_allocated_reg;
    logic        entry_valid_reg;
    logic        entry_writable_reg;
    logic [31:0] entry_address_reg;

    // Storage interface
    store_wr_t     store_wr;
    logic [IW-1:0] wr_index;
    logic [IW-1:0] rd_index;
    logic [15:0]   rd_page;
    logic [15:0]   rd_owner;
    logic [31:0]   rd_address;

    logic [IW-1:0] ptr_idx;
    logic [CW-1:0] run_next;
    logic          run_done;
    logic          entry_ok;
    logic [15:0]   owner_eff;
    logic          map_match;
    logic          find_match;
    logic          out_free;

    assign ptr_idx  = ptr_reg[IW-1:0];
    assign run_next = run_reg + 1'b1;
    assign run_done = (CMPW'(run_next) == CMPW'(count_reg));
    assign entry_ok = (32'(entry_index) < ENTRIES);
    assign out_free = !out_valid_reg || out_ready;

    // Compare the word read back for the entry under test
    assign owner_eff  = alloc_flags_reg[cmp_idx_reg] ? rd_owner : ID_EMPTY;
    assign map_match  = !valid_flags_reg[cmp_idx_reg] && (owner_eff == tag_reg);
    assign find_match = valid_flags_reg[cmp_idx_reg] && (rd_address == addr_reg);

    // Drive the storage ports
    always_comb
    begin
        store_wr.page_we = (state_reg == ALLOC_WRITE);
        store_wr.addr_we = (state_reg == MAP_SCAN) && cmp_ok_reg && map_match;
        wr_index         = (state_reg == ALLOC_WRITE) ? wptr_reg : cmp_idx_reg;
        rd_index         = (state_reg == IDLE) ? IW'(entry_index) : ptr_idx;
    end

    cpat_store #(
        .ENTRIES(ENTRIES)
    ) u_store (
        .clk        (clk),
        .wr         (store_wr),
        .wr_index   (wr_index),
        .wr_page    (last_page_reg + 16'd1),
        .wr_owner   (last_alloc_reg),
        .wr_address (addr_reg),
        .rd_index   (rd_index),
        .rd_page    (rd_page),
        .rd_owner   (rd_owner),
        .rd_address (rd_address)
    );

    // Sequencer, entry flags and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= IDLE;
            out_valid_reg   <= 1'b0;
            alloc_flags_reg <= '0;
            valid_flags_reg <= '0;
            bound_flags_reg <= '0;
            write_flags_reg <= '0;
            last_alloc_reg  <= ID_EMPTY;
            last_page_reg   <= ID_EMPTY;
            ptr_reg         <= '0;
            run_reg         <= '0;
            cmp_ok_reg      <= 1'b0;
            remain_reg      <= '0;
        end
        else
        begin
            // Drop the result once taken, unless a new one is posted now
            if (out_valid_reg && out_ready && state_reg != RESP)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                IDLE:
                begin
                    if (in_valid)
                    begin
                        count_reg      <= page_count;
                        tag_reg        <= alloc_tag;
                        addr_reg       <= target_address;
                        idx_reg        <= IW'(entry_index);
                        idx_ok_reg     <= entry_ok;
                        ptr_reg        <= '0;
                        run_reg        <= '0;
                        cmp_ok_reg     <= 1'b0;
                        res_status_reg <= ST_OK;
                        res_id_reg     <= '0;
                        res_page_reg   <= '0;
                        res_hit_reg    <= '0;
                        res_alloc_reg  <= 1'b0;
                        res_valid_reg  <= 1'b0;
                        res_write_reg  <= 1'b0;
                        res_addr_reg   <= '0;
                        case (func)
                            FUNC_ALLOC:
                            begin
                                if (page_count == 6'd0 || 32'(page_count) > ENTRIES)
                                begin
                                    res_status_reg <= ST_NO_RUN;
                                    state_reg      <= RESP;
                                end
                                else
                                begin
                                    state_reg <= ALLOC_SCAN;
                                end
                            end
                            FUNC_MAP:
                            begin
                                state_reg <= MAP_SCAN;
                            end
                            FUNC_FIND:
                            begin
                                state_reg <= FIND_SCAN;
                            end
                            FUNC_INVAL:
                            begin
                                if (entry_ok)
                                begin
                                    valid_flags_reg[IW'(entry_index)] <= 1'b0;
                                end
                                state_reg <= RESP;
                            end
                            FUNC_READ:
                            begin
                                state_reg <= READ_WAIT;
                            end
                            default:
                            begin
                                state_reg <= RESP;
                            end
                        endcase
                    end
                end

                ALLOC_SCAN:
                begin
                    // Extend or break the current free run
                    if (alloc_flags_reg[ptr_idx])
                    begin
                        run_reg <= '0;
                    end
                    else
                    begin
                        run_reg <= run_next;
                        if (run_reg == '0)
                        begin
                            start_reg <= ptr_idx;
                        end
                    end
                    if (!alloc_flags_reg[ptr_idx] && run_done)
                    begin
                        wptr_reg       <= (run_reg == '0) ? ptr_idx : start_reg;
                        remain_reg     <= count_reg;
                        last_alloc_reg <= last_alloc_reg + 16'd1;
                        res_id_reg     <= last_alloc_reg + 16'd1;
                        res_page_reg   <= last_page_reg + 16'd1;
                        state_reg      <= ALLOC_WRITE;
                    end
                    else if (ptr_reg == CW'(ENTRIES - 1))
                    begin
                        res_status_reg <= ST_NO_RUN;
                        state_reg      <= RESP;
                    end
                    else
                    begin
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                end

                ALLOC_WRITE:
                begin
                    // Claim one entry of the run per cycle
                    alloc_flags_reg[wptr_reg] <= 1'b1;
                    write_flags_reg[wptr_reg] <= 1'b1;
                    last_page_reg             <= last_page_reg + 16'd1;
                    wptr_reg                  <= wptr_reg + 1'b1;
                    remain_reg                <= remain_reg - 6'd1;
                    if (remain_reg == 6'd1)
                    begin
                        state_reg <= RESP;
                    end
                end

                MAP_SCAN:
                begin
                    if (cmp_ok_reg && map_match)
                    begin
                        valid_flags_reg[cmp_idx_reg] <= 1'b1;
                        bound_flags_reg[cmp_idx_reg] <= 1'b1;
                        res_page_reg <= alloc_flags_reg[cmp_idx_reg] ? rd_page : ID_EMPTY;
                        state_reg    <= RESP;
                    end
                    else if (!cmp_ok_reg && ptr_reg == MAP_LIM)
                    begin
                        res_status_reg <= ST_NO_ENTRY;
                        state_reg      <= RESP;
                    end
                    else
                    begin
                        // Issue the next read while comparing the last one
                        if (ptr_reg != MAP_LIM)
                        begin
                            ptr_reg <= ptr_reg + 1'b1;
                        end
                        cmp_ok_reg  <= (ptr_reg != MAP_LIM);
                        cmp_idx_reg <= ptr_idx;
                    end
                end

                FIND_SCAN:
                begin
                    if (cmp_ok_reg && find_match)
                    begin
                        res_hit_reg <= 5'(cmp_idx_reg);
                        state_reg   <= RESP;
                    end
                    else if (!cmp_ok_reg && ptr_reg == FIND_LIM)
                    begin
                        res_hit_reg <= 5'(LOOKUP_ENTRIES);
                        state_reg   <= RESP;
                    end
                    else
                    begin
                        if (ptr_reg != FIND_LIM)
                        begin
                            ptr_reg <= ptr_reg + 1'b1;
                        end
                        cmp_ok_reg  <= (ptr_reg != FIND_LIM);
                        cmp_idx_reg <= ptr_idx;
                    end
                end

                READ_WAIT:
                begin
                    // Read word arrived; substitute empty values where unset
                    if (idx_ok_reg)
                    begin
                        res_page_reg  <= alloc_flags_reg[idx_reg] ? rd_page : ID_EMPTY;
                        res_alloc_reg <= alloc_flags_reg[idx_reg];
                        res_valid_reg <= valid_flags_reg[idx_reg];
                        res_write_reg <= write_flags_reg[idx_reg];
                        res_addr_reg  <= bound_flags_reg[idx_reg] ? rd_address : ADDR_EMPTY;
                    end
                    else
                    begin
                        res_page_reg <= ID_EMPTY;
                        res_addr_reg <= ADDR_EMPTY;
                    end
                    state_reg <= RESP;
                end

                RESP:
                begin
                    // Hold until the output register is free
                    if (out_free)
                    begin
                        out_valid_reg       <= 1'b1;
                        status_reg          <= res_status_reg;
                        new_alloc_id_reg    <= res_id_reg;
                        page_number_reg     <= res_page_reg;
                        hit_index_reg       <= res_hit_reg;
                        entry_allocated_reg <= res_alloc_reg;
                        entry_valid_reg     <= res_valid_reg;
                        entry_writable_reg  <= res_write_reg;
                        entry_address_reg   <= res_addr_reg;
                        state_reg           <= IDLE;
                    end
                end

                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign in_ready        = (state_reg == IDLE);
    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign new_alloc_id    = new_alloc_id_reg;
    assign page_number     = page_number_reg;
    assign hit_index       = hit_index_reg;
    assign entry_allocated = entry_allocated_reg;
    assign entry_valid     = entry_valid_reg;
    assign entry_writable  = entry_writable_reg;
    assign entry_address   = entry_address_reg;

endmodule

>>> hdl/cpat_checker.sv
// Port-level checks for the contiguous page allocator table, bound to the top level.
// Depends on cpat_pkg and contiguous_page_allocator_table.
`timescale 1ns / 1ps

module cpat_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [15:0] new_alloc_id,
    input logic [15:0] page_number,
    input logic [4:0]  hit_index,
    input logic [31:0] entry_address
);
    import cpat_pkg::*;

    // One word at a time: an accepted word closes the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted again while a word is in work");

    // A waiting result holds its word
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(status)
            && $stable(page_number) && $stable(entry_address)))
        else $error("result changed before it was taken");

    // Only defined status codes appear
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK || status == ST_NO_RUN || status == ST_NO_ENTRY))
        else $error("undefined status code");

    // A failed word reports nothing else
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (new_alloc_id == 16'd0 && page_number == 16'd0
            && hit_index == 5'd0 && entry_address == 32'd0))
        else $error("failed result carries data");

endmodule

bind contiguous_page_allocator_table cpat_checker u_cpat_checker (.*);

>>> dv/tb_contiguous_page_allocator_table.sv
// Testbench for contiguous_page_allocator_table: directed and random words
// checked field by field against a predictor of the page table and allocator.
// Depends on hdl/cpat_pkg.sv and hdl/contiguous_page_allocator_table.sv.
`timescale 1ns / 1ps

module tb_contiguous_page_allocator_table;
    import cpat_pkg::*;

    localparam int ENTRY_COUNT    = 32;
    localparam int LOOKUP_COUNT   = 16;
    localparam int SCAN_COUNT     = (LOOKUP_COUNT < ENTRY_COUNT) ? LOOKUP_COUNT : ENTRY_COUNT;
    localparam int RANDOM_WORDS   = 1260;
    localparam int SETTLE_CYCLES  = 2 * ENTRY_COUNT + 20;
    localparam int WATCHDOG_LIMIT = 4000;

    // Highest function code; codes above FUNC_READ do nothing
    localparam logic [2:0] FUNC_LAST = 3'd7;

    // One input word; wait_idle holds it back until every result is in
    typedef struct packed {
        logic [2:0]  op;
        logic [5:0]  count;
        logic [15:0] tag;
        logic [31:0] addr;
        logic [4:0]  index;
        logic        wait_idle;
    } word_t;

    // One result word, in port order
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] alloc_id;
        logic [15:0] page;
        logic [4:0]  hit;
        logic        allocated;
        logic        valid;
        logic        writable;
        logic [31:0] address;
    } reply_t;

    // Contents of the page table and the id counters
    typedef struct packed {
        logic [ENTRY_COUNT-1:0]       allocated;
        logic [ENTRY_COUNT-1:0]       valid;
        logic [ENTRY_COUNT-1:0]       writable;
        logic [ENTRY_COUNT-1:0][15:0] page_id;
        logic [ENTRY_COUNT-1:0][15:0] owner;
        logic [ENTRY_COUNT-1:0][31:0] address;
        logic [15:0]                  last_alloc;
        logic [15:0]                  last_page;
    } table_t;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_MASK, RX_SLOW} rx_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  func = '0;
    logic [5:0]  page_count = '0;
    logic [15:0] alloc_tag = '0;
    logic [31:0] target_address = '0;
    logic [4:0]  entry_index = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [15:0] new_alloc_id;
    logic [15:0] page_number;
    logic [4:0]  hit_index;
    logic        entry_allocated;
    logic        entry_valid;
    logic        entry_writable;
    logic [31:0] entry_address;

    word_t    pending_words[$];
    reply_t   expected_replies[$];
    table_t   page_table;
    table_t   planned_table;
    logic     in_taken = 1'b0;
    int       fail_count = 0;
    int       idle_cycles = 0;
    int       burst_left = 0;
    int       gap_left = 0;
    rx_mode_t rx_mode = RX_OPEN;
    int       rx_left = 0;
    logic [7:0] rx_mask = 8'h01;

    contiguous_page_allocator_table #(
        .ENTRIES        (ENTRY_COUNT),
        .LOOKUP_ENTRIES (LOOKUP_COUNT)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .page_count      (page_count),
        .alloc_tag       (alloc_tag),
        .target_address  (target_address),
        .entry_index     (entry_index),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .new_alloc_id    (new_alloc_id),
        .page_number     (page_number),
        .hit_index       (hit_index),
        .entry_allocated (entry_allocated),
        .entry_valid     (entry_valid),
        .entry_writable  (entry_writable),
        .entry_address   (entry_address)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Table contents right after reset
    function automatic table_t empty_table();
        table_t t;
        int k;
        t.allocated = '0;
        t.valid     = '0;
        t.writable  = '0;
        for (k = 0; k < ENTRY_COUNT; k++)
        begin
            t.page_id[k] = ID_EMPTY;
            t.owner[k]   = ID_EMPTY;
            t.address[k] = ADDR_EMPTY;
        end
        t.last_alloc = ID_EMPTY;
        t.last_page  = ID_EMPTY;
        return t;
    endfunction

    // Apply one word to a table; return the new table and the result word
    function automatic table_t page_table_step(input table_t s, input word_t w,
                                               output reply_t r);
        table_t n;
        int run;
        int first;
        int slot;
        int hit;
        int k;
        bit found;
        n = s;
        r = '0;
        run = 0;
        first = 0;
        slot = 0;
        hit = LOOKUP_COUNT;
        found = 1'b0;
        case (w.op)
            FUNC_ALLOC:
            begin
                // First fit: lowest run of count free entries
                if (w.count != 0 && w.count <= ENTRY_COUNT)
                begin
                    for (k = 0; k < ENTRY_COUNT && !found; k++)
                    begin
                        if (s.allocated[k])
                            run = 0;
                        else
                        begin
                            run++;
                            if (run == w.count)
                            begin
                                first = k + 1 - w.count;
                                found = 1'b1;
                            end
                        end
                    end
                end
                if (!found)
                    r.status = ST_NO_RUN;
                else
                begin
                    n.last_alloc = s.last_alloc + 16'd1;
                    r.alloc_id   = n.last_alloc;
                    r.page       = s.last_page + 16'd1;
                    for (k = 0; k < w.count; k++)
                    begin
                        n.last_page = n.last_page + 16'd1;
                        n.allocated[first + k] = 1'b1;
                        n.page_id[first + k]   = n.last_page;
                        n.owner[first + k]     = n.last_alloc;
                        n.writable[first + k]  = 1'b1;
                    end
                end
            end
            FUNC_MAP:
            begin
                // Bind the lowest entry owned by the tag that is not valid
                for (k = 0; k < ENTRY_COUNT; k++)
                begin
                    if (!found && !s.valid[k] && s.owner[k] == w.tag)
                    begin
                        slot = k;
                        found = 1'b1;
                    end
                end
                if (!found)
                    r.status = ST_NO_ENTRY;
                else
                begin
                    n.address[slot] = w.addr;
                    n.valid[slot]   = 1'b1;
                    r.page          = s.page_id[slot];
                end
            end
            FUNC_FIND:
            begin
                for (k = 0; k < SCAN_COUNT; k++)
                begin
                    if (!found && s.valid[k] && s.address[k] == w.addr)
                    begin
                        hit = k;
                        found = 1'b1;
                    end
                end
                r.hit = 5'(hit);
            end
            FUNC_INVAL:
            begin
                n.valid[w.index] = 1'b0;
            end
            FUNC_READ:
            begin
                r.page      = s.page_id[w.index];
                r.allocated = s.allocated[w.index];
                r.valid     = s.valid[w.index];
                r.writable  = s.writable[w.index];
                r.address   = s.address[w.index];
            end
            default:
            begin
            end
        endcase
        return n;
    endfunction

    function automatic word_t make_word(logic [2:0] op, logic [5:0] count, logic [15:0] tag,
                                        logic [31:0] addr, logic [4:0] index);
        word_t w;
        w.op        = op;
        w.count     = count;
        w.tag       = tag;
        w.addr      = addr;
        w.index     = index;
        w.wait_idle = 1'b0;
        return w;
    endfunction

    function automatic word_t random_word(logic [2:0] op);
        return make_word(op, 6'($urandom), 16'($urandom), $urandom, 5'($urandom));
    endfunction

    // Queue a word and track the table it leaves behind, to steer later words
    task automatic plan_word(input word_t w);
        reply_t unused;
        planned_table = page_table_step(planned_table, w, unused);
        pending_words.push_back(w);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    // Sender: bursts of words with random gaps, payload held until taken
    always @(negedge clk)
    begin : sender
        word_t w;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && !in_taken)
            in_valid <= 1'b1;
        else if (gap_left > 0)
        begin
            in_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (pending_words.size() == 0 ||
                 (pending_words[0].wait_idle && expected_replies.size() != 0))
            in_valid <= 1'b0;
        else
        begin
            w = pending_words.pop_front();
            func           <= w.op;
            page_count     <= w.count;
            alloc_tag      <= w.tag;
            target_address <= w.addr;
            entry_index    <= w.index;
            in_valid       <= 1'b1;
            if (burst_left <= 1)
            begin
                burst_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                          : $urandom_range(1, 8);
                gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            end
            else
                burst_left <= burst_left - 1;
        end
    end

    // Receiver: switch among stall patterns, each held for a random span
    always @(negedge clk)
    begin : receiver
        if (rx_left == 0)
        begin
            rx_mode   <= rx_mode_t'($urandom_range(0, 3));
            rx_left   <= $urandom_range(40, 300);
            rx_mask   <= 8'($urandom) | 8'h01;
            out_ready <= 1'b1;
        end
        else
        begin
            rx_left <= rx_left - 1;
            case (rx_mode)
                RX_OPEN:
                    out_ready <= 1'b1;
                RX_COIN:
                    out_ready <= 1'($urandom_range(0, 1));
                RX_MASK:
                begin
                    out_ready <= rx_mask[0];
                    rx_mask   <= {rx_mask[0], rx_mask[7:1]};
                end
                default:
                    out_ready <= (rx_left % 4 == 0);
            endcase
        end
    end

    // Monitor: check results, predict accepted words, watch for a hang
    always @(posedge clk)
    begin : monitor
        reply_t want;
        reply_t got;
        word_t seen;
        if (rst_n)
        begin
            in_taken <= in_valid && in_ready;

            // Check a result before predicting a word taken on the same edge
            if (out_valid && out_ready)
            begin
                got = {status, new_alloc_id, page_number, hit_index, entry_allocated,
                       entry_valid, entry_writable, entry_address};
                if (expected_replies.size() == 0)
                begin
                    $error("result word with no expectation: status %0h page %0h",
                           got.status, got.page);
                    fail_count++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("new_alloc_id", 32'(want.alloc_id), 32'(got.alloc_id));
                    check_field("page_number", 32'(want.page), 32'(got.page));
                    check_field("hit_index", 32'(want.hit), 32'(got.hit));
                    check_field("entry_allocated", 32'(want.allocated),
                                32'(got.allocated));
                    check_field("entry_valid", 32'(want.valid), 32'(got.valid));
                    check_field("entry_writable", 32'(want.writable), 32'(got.writable));
                    check_field("entry_address", want.address, got.address);
                end
            end

            if (in_valid && in_ready)
            begin
                seen = {func, page_count, alloc_tag, target_address, entry_index, 1'b0};
                page_table = page_table_step(page_table, seen, want);
                expected_replies.push_back(want);
            end

            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        word_t w;
        int picks[$];
        logic [31:0] addr_pool[4];
        int plain;
        int roll;
        int k;

        page_table    = empty_table();
        planned_table = empty_table();
        for (k = 0; k < 4; k++)
            addr_pool[k] = $urandom;

        // Directed: reset contents, failures, first fit, map, find, window
        plan_word(make_word(FUNC_READ, 6'd0, 16'h0000, 32'h0, 5'd0));
        plan_word(make_word(FUNC_FIND, 6'd0, 16'h0000, ADDR_EMPTY, 5'd0));
        plan_word(make_word(FUNC_MAP, 6'd0, ID_EMPTY, addr_pool[0], 5'd0));
        plan_word(make_word(FUNC_MAP, 6'd0, 16'h1234, addr_pool[1], 5'd0));
        plan_word(make_word(FUNC_ALLOC, 6'd0, 16'h0, 32'h0, 5'd0));
        plan_word(make_word(FUNC_ALLOC, 6'd33, 16'h0, 32'h0, 5'd0));
        plan_word(make_word(FUNC_ALLOC, 6'd63, 16'hFFFF, ADDR_EMPTY, 5'd31));
        plan_word(make_word(FUNC_ALLOC, 6'd1, 16'h0, 32'h0, 5'd0));
        plan_word(make_word(FUNC_ALLOC, 6'd3, 16'h0, 32'h0, 5'd0));
        plan_word(make_word(FUNC_MAP, 6'd0, 16'h0001, 32'h0000_0000, 5'd0));
        plan_word(make_word(FUNC_MAP, 6'd0, 16'h0001, 32'hFFFF_FFFE, 5'd0));
        plan_word(make_word(FUNC_MAP, 6'd0, 16'h0000, addr_pool[2], 5'd0));
        plan_word(make_word(FUNC_FIND, 6'd0, 16'h0, 32'h0000_0000, 5'd0));
        plan_word(make_word(FUNC_FIND, 6'd0, 16'h0, addr_pool[0], 5'd0));
        plan_word(make_word(FUNC_INVAL, 6'd0, 16'h0, 32'h0, 5'd1));
        plan_word(make_word(FUNC_FIND, 6'd0, 16'h0, 32'h0000_0000, 5'd0));
        plan_word(make_word(FUNC_READ, 6'd0, 16'h0, 32'h0, 5'd1));
        plan_word(make_word(FUNC_READ, 6'd0, 16'h0, 32'h0, 5'd2));
        plan_word(make_word(FUNC_READ, 6'd0, 16'h0, 32'h0, 5'd31));
        plan_word(make_word(FUNC_ALLOC, 6'd32, 16'h0, 32'h0, 5'd0));
        plan_word(make_word(FUNC_ALLOC, 6'd20, 16'h0, 32'h0, 5'd0));
        plan_word(make_word(FUNC_MAP, 6'd0, 16'h0002, addr_pool[3], 5'd0));
        plan_word(random_word(FUNC_READ + 3'd1));
        plan_word(random_word(FUNC_LAST));

        // Random: mostly well-formed maps and finds against the planned table
        plain = 0;
        while (plain < RANDOM_WORDS)
        begin
            roll = $urandom_range(0, 99);
            picks.delete();
            if (roll < 8)
            begin
                w = random_word(FUNC_ALLOC);
                if ($urandom_range(0, 4) != 0)
                    w.count = 6'($urandom_range(1, 4));
            end
            else if (roll < 43)
            begin
                w = random_word(FUNC_MAP);
                for (k = 0; k < ENTRY_COUNT; k++)
                    if (planned_table.allocated[k] && !planned_table.valid[k])
                        picks.push_back(k);
                if (picks.size() != 0 && $urandom_range(0, 9) < 8)
                    w.tag = planned_table.owner[picks[$urandom_range(0, picks.size() - 1)]];
                else if ($urandom_range(0, 1) == 0)
                    w.tag = ID_EMPTY;
                if ($urandom_range(0, 2) == 0)
                    w.addr = addr_pool[$urandom_range(0, 3)];
            end
            else if (roll < 68)
            begin
                w = random_word(FUNC_FIND);
                for (k = 0; k < ENTRY_COUNT; k++)
                    if (planned_table.valid[k])
                        picks.push_back(k);
                if (picks.size() != 0 && $urandom_range(0, 9) < 7)
                    w.addr = planned_table.address[picks[$urandom_range(0, picks.size() - 1)]];
                else if ($urandom_range(0, 1) == 0)
                    w.addr = addr_pool[$urandom_range(0, 3)];
            end
            else if (roll < 83)
            begin
                w = random_word(FUNC_INVAL);
                for (k = 0; k < ENTRY_COUNT; k++)
                    if (planned_table.valid[k])
                        picks.push_back(k);
                if (picks.size() != 0 && $urandom_range(0, 9) < 7)
                    w.index = 5'(picks[$urandom_range(0, picks.size() - 1)]);
            end
            else if (roll < 95)
                w = random_word(FUNC_READ);
            else
                w = random_word(3'($urandom_range(FUNC_READ + 1, FUNC_LAST)));

            if (w.op <= FUNC_READ)
                plain++;
            // Drain the block before the first random word and now and then
            w.wait_idle = (plain == 1) || ($urandom_range(0, 299) == 0);
            plan_word(w);
        end

        // Release reset away from the sampling edge
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || in_valid || expected_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0 && expected_replies.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> filelist.f
hdl/cpat_pkg.sv
hdl/cpat_store.sv
hdl/contiguous_page_allocator_table.sv
hdl/cpat_checker.sv
dv/tb_contiguous_page_allocator_table.sv
